// ===== hw/rtl/kwm_pkg.sv =====
// Shared types and constants for the k-way sorted merge unit.
// Holds item kinds, result status codes, controller states and the list table controls.
// No dependencies.
`timescale 1ns / 1ps

package kwm_pkg;

  // Fixed port field widths.
  localparam int unsigned KindW    = 2;
  localparam int unsigned ListIdxW = 4;
  localparam int unsigned ValueW   = 16;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned SrcW     = 4;

  // Kind of an input item.
  typedef enum logic [KindW-1:0] {
    KindLoad  = 2'd0,
    KindTake  = 2'd1,
    KindClear = 2'd2,
    KindNone  = 2'd3
  } kind_e;

  // Status of a result item.
  typedef enum logic [StatusW-1:0] {
    StatLoaded  = 3'd0,
    StatDropped = 3'd1,
    StatTaken   = 3'd2,
    StatEmpty   = 3'd3,
    StatCleared = 3'd4
  } status_e;

  // Controller states.
  typedef enum logic [1:0] {
    StIdle   = 2'd0,
    StLookup = 2'd1,
    StFetch  = 2'd2
  } state_e;

  // Controls from the controller to the list table.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clear;
  } tbl_ctrl_t;

endpackage

// ===== hw/rtl/kwm_elem_ram.sv =====
// Element store: simple dual-port synchronous RAM with registered read data.
// One write port and one read port; no dependencies.
`timescale 1ns / 1ps

module kwm_elem_ram #(
  parameter int unsigned DEPTH = 8192,
  parameter int unsigned WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/kwm_list_table.sv =====
// List table: read position and fill level of every list in a synchronous memory.
// A valid bit per entry makes a clear take effect at once; depends on kwm_pkg.
`timescale 1ns / 1ps

module kwm_list_table
  import kwm_pkg::*;
#(
  parameter int unsigned LISTS      = 16,
  parameter int unsigned LIST_DEPTH = 512
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  tbl_ctrl_t                        ctrl_i,
  input  logic [$clog2(LISTS)-1:0]         rd_addr_i,
  input  logic [$clog2(LISTS)-1:0]         wr_addr_i,
  input  logic [$clog2(LIST_DEPTH+1)-1:0]  wr_rpos_i,
  input  logic [$clog2(LIST_DEPTH+1)-1:0]  wr_fill_i,
  output logic [$clog2(LIST_DEPTH+1)-1:0]  rd_rpos_o,
  output logic [$clog2(LIST_DEPTH+1)-1:0]  rd_fill_o
);

  localparam int unsigned PW = $clog2(LIST_DEPTH + 1);

  logic [2*PW-1:0] mem [LISTS];
  logic [2*PW-1:0] rdata_q;
  logic [LISTS-1:0] valid_q;
  logic            hit_q;

  // Entry storage, written back by the controller.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem[wr_addr_i] <= {wr_rpos_i, wr_fill_i};
    end
    if (ctrl_i.rd_en) begin
      rdata_q <= mem[rd_addr_i];
    end
  end

  // Valid bits: a single clear empties every list.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      hit_q   <= 1'b0;
    end else begin
      if (ctrl_i.clear) begin
        valid_q <= '0;
      end else if (ctrl_i.wr_en) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (ctrl_i.rd_en) begin
        hit_q <= valid_q[rd_addr_i];
      end
    end
  end

  // An entry that is not valid reads as an empty list.
  assign rd_rpos_o = hit_q ? rdata_q[2*PW-1:PW] : '0;
  assign rd_fill_o = hit_q ? rdata_q[PW-1:0] : '0;

endmodule

// ===== hw/rtl/kwm_min_tree.sv =====
// Comparator tree that finds the smallest cached head among the non-empty lists.
// Ties resolve to the lowest list index; no dependencies.
`timescale 1ns / 1ps

module kwm_min_tree #(
  parameter int unsigned LISTS       = 16,
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  logic [LISTS-1:0]                  valid_i,
  input  logic [LISTS-1:0][VALUE_WIDTH-1:0] heads_i,
  output logic                              found_o,
  output logic [$clog2(LISTS)-1:0]          idx_o,
  output logic [VALUE_WIDTH-1:0]            value_o
);

  localparam int unsigned LW    = $clog2(LISTS);
  localparam int unsigned LEAFS = 1 << LW;
  localparam int unsigned NODES = 2 * LEAFS - 1;

  logic                          node_vld [NODES];
  logic signed [VALUE_WIDTH-1:0] node_val [NODES];
  logic [LW-1:0]                 node_idx [NODES];

  // Leaves in list order, so a left child always holds the lower indices.
  for (genvar j = 0; j < LEAFS; j++) begin : g_leaf
    if (j < LISTS) begin : g_used
      assign node_vld[LEAFS-1+j] = valid_i[j];
      assign node_val[LEAFS-1+j] = heads_i[j];
      assign node_idx[LEAFS-1+j] = LW'(j);
    end else begin : g_pad
      assign node_vld[LEAFS-1+j] = 1'b0;
      assign node_val[LEAFS-1+j] = '0;
      assign node_idx[LEAFS-1+j] = '0;
    end
  end

  // Left child wins unless the right is strictly smaller or the left is invalid.
  for (genvar i = 0; i < LEAFS - 1; i++) begin : g_node
    logic pick_r;
    assign pick_r = node_vld[2*i+2] &&
                    (!node_vld[2*i+1] || (node_val[2*i+2] < node_val[2*i+1]));
    assign node_vld[i] = node_vld[2*i+1] || node_vld[2*i+2];
    assign node_val[i] = pick_r ? node_val[2*i+2] : node_val[2*i+1];
    assign node_idx[i] = pick_r ? node_idx[2*i+2] : node_idx[2*i+1];
  end

  assign found_o = node_vld[0];
  assign idx_o   = node_idx[0];
  assign value_o = node_val[0];

endmodule

// ===== hw/rtl/k_way_sorted_merge_unit.sv =====
// K-way sorted merge unit: LISTS ascending lists of signed values merged on demand.
// Uses kwm_pkg, kwm_min_tree, kwm_list_table and kwm_elem_ram.
//
// Input channel (in_valid_i / in_stall_o) carries kind_i, list_index_i and value_i.
// A load appends value_i to list list_index_i, a take returns the smallest head
// (lowest list on a tie) and advances that list, a clear empties all lists.
// Output channel (out_valid_o / out_stall_i) returns one result per item:
// status_o, taken_value_o and source_list_o.
//
// Every item passes the lookup state, which uses the list table read; a load, a
// clear and a take that empties its list then return to idle. A take that leaves
// its list non-empty also passes the fetch state for the element RAM read of the
// new head. The result is registered when the lookup completes. The output
// register holds one result; the next item is taken in while it waits, and the
// unit holds in the lookup cycle only when a second result is ready and the
// receiver still stalls.
// Reset empties all lists at once through per-list valid bits; no clearing pass
// runs, and the element RAM is never cleared.
`timescale 1ns / 1ps

module k_way_sorted_merge_unit
  import kwm_pkg::*;
#(
  parameter int unsigned LISTS       = 16,
  parameter int unsigned LIST_DEPTH  = 512,
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [KindW-1:0]           kind_i,
  input  logic [ListIdxW-1:0]        list_index_i,
  input  logic signed [ValueW-1:0]   value_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [StatusW-1:0]         status_o,
  output logic signed [ValueW-1:0]   taken_value_o,
  output logic [SrcW-1:0]            source_list_o
);

  localparam int unsigned LW    = $clog2(LISTS);
  localparam int unsigned PW    = $clog2(LIST_DEPTH + 1);
  localparam int unsigned EDEPTH = LISTS * LIST_DEPTH;
  localparam int unsigned EW    = $clog2(EDEPTH);

  // Controller state and the item under work.
  state_e                        state_q, state_d;
  kind_e                         kind_q;
  logic [LW-1:0]                 list_q;
  logic                          in_range_q;
  logic                          found_q;
  logic signed [VALUE_WIDTH-1:0] val_q;

  // Per-list cached heads and non-empty flags.
  logic [LISTS-1:0][VALUE_WIDTH-1:0] head_q;
  logic [LISTS-1:0]                  ne_q;

  // Output register.
  logic                          out_valid_q;
  status_e                       status_q;
  logic signed [ValueW-1:0]      taken_q;
  logic [SrcW-1:0]               src_q;

  logic                          accept;
  logic                          out_free;
  kind_e                         kind_in;
  logic                          in_range;
  logic [LW-1:0]                 load_list;
  logic signed [VALUE_WIDTH-1:0] load_val;

  logic                          tree_found;
  logic [LW-1:0]                 tree_idx;
  logic [VALUE_WIDTH-1:0]        tree_val;

  tbl_ctrl_t                     tbl_ctrl;
  logic [LW-1:0]                 tbl_rd_addr;
  logic [PW-1:0]                 tbl_wr_rpos, tbl_wr_fill;
  logic [PW-1:0]                 tbl_rpos, tbl_fill;

  logic                          act;
  logic [PW-1:0]                 rpos_next;
  logic                          more;
  logic                          list_full;
  logic [EW-1:0]                 elem_addr;
  logic                          elem_we, elem_re;
  logic [VALUE_WIDTH-1:0]        elem_rdata;

  logic                          head_we;
  logic [VALUE_WIDTH-1:0]        head_wdata;
  logic                          ne_set, ne_clr, ne_clr_all;
  status_e                       res_status;

  // Input side decode.
  assign in_stall_o = (state_q != StIdle);
  assign accept     = in_valid_i && !in_stall_o;
  assign kind_in    = kind_e'(kind_i);
  assign in_range   = 32'(list_index_i) < LISTS;
  assign load_list  = in_range ? LW'(list_index_i) : '0;
  assign load_val   = VALUE_WIDTH'(value_i);
  assign out_free   = !out_valid_q || !out_stall_i;

  kwm_min_tree #(
    .LISTS       (LISTS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_min_tree (
    .valid_i (ne_q),
    .heads_i (head_q),
    .found_o (tree_found),
    .idx_o   (tree_idx),
    .value_o (tree_val)
  );

  kwm_list_table #(
    .LISTS      (LISTS),
    .LIST_DEPTH (LIST_DEPTH)
  ) u_list_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (tbl_ctrl),
    .rd_addr_i (tbl_rd_addr),
    .wr_addr_i (list_q),
    .wr_rpos_i (tbl_wr_rpos),
    .wr_fill_i (tbl_wr_fill),
    .rd_rpos_o (tbl_rpos),
    .rd_fill_o (tbl_fill)
  );

  kwm_elem_ram #(
    .DEPTH (EDEPTH),
    .WIDTH (VALUE_WIDTH)
  ) u_elem_ram (
    .clk_i   (clk_i),
    .we_i    (elem_we),
    .waddr_i (elem_addr),
    .wdata_i (val_q),
    .re_i    (elem_re),
    .raddr_i (elem_addr),
    .rdata_o (elem_rdata)
  );

  // Lookup cycle arithmetic on the list table entry.
  assign act       = (state_q == StLookup) && out_free;
  assign rpos_next = tbl_rpos + PW'(1);
  assign more      = rpos_next < tbl_fill;
  assign list_full = tbl_fill == PW'(LIST_DEPTH);
  assign elem_addr = EW'(list_q) * EW'(LIST_DEPTH) +
                     EW'((kind_q == KindLoad) ? tbl_fill : rpos_next);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = StLookup;
        end
      end
      StLookup: begin
        if (out_free) begin
          state_d = elem_re ? StFetch : StIdle;
        end
      end
      StFetch: begin
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Controller outputs: table, element RAM, head cache and result.
  always_comb begin
    tbl_ctrl    = '0;
    tbl_rd_addr = (kind_in == KindTake) ? tree_idx : load_list;
    tbl_wr_rpos = tbl_rpos;
    tbl_wr_fill = tbl_fill;
    elem_we     = 1'b0;
    elem_re     = 1'b0;
    head_we     = 1'b0;
    head_wdata  = val_q;
    ne_set      = 1'b0;
    ne_clr      = 1'b0;
    ne_clr_all  = 1'b0;
    res_status  = StatLoaded;
    unique case (state_q)
      StIdle: begin
        tbl_ctrl.rd_en = accept;
      end
      StLookup: begin
        unique case (kind_q)
          KindLoad: begin
            if (in_range_q && !list_full) begin
              res_status       = StatLoaded;
              tbl_ctrl.wr_en   = act;
              tbl_wr_fill      = tbl_fill + PW'(1);
              elem_we          = act;
              head_we          = act && (tbl_rpos >= tbl_fill);
              ne_set           = act;
            end else begin
              res_status = StatDropped;
            end
          end
          KindTake: begin
            if (found_q) begin
              res_status     = StatTaken;
              tbl_ctrl.wr_en = act;
              tbl_wr_rpos    = rpos_next;
              elem_re        = act && more;
              ne_clr         = act && !more;
            end else begin
              res_status = StatEmpty;
            end
          end
          KindClear: begin
            res_status     = StatCleared;
            tbl_ctrl.clear = act;
            ne_clr_all     = act;
          end
          KindNone: begin
            res_status = StatLoaded;
          end
          default: begin
            res_status = StatLoaded;
          end
        endcase
      end
      StFetch: begin
        head_we    = 1'b1;
        head_wdata = elem_rdata;
      end
      default: begin
        tbl_ctrl = '0;
      end
    endcase
  end

  // Controller registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      kind_q  <= KindNone;
    end else begin
      state_q <= state_d;
      if (accept) begin
        kind_q <= kind_in;
      end
    end
  end

  // Item payload captured at the input transfer.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_range_q <= in_range;
      found_q    <= tree_found;
      list_q     <= (kind_in == KindTake) ? tree_idx : load_list;
      val_q      <= (kind_in == KindTake) ? tree_val : load_val;
    end
  end

  // Head cache, written by a load into an empty list or by the refill read.
  always_ff @(posedge clk_i) begin
    if (head_we) begin
      head_q[list_q] <= head_wdata;
    end
  end

  // Non-empty flags feed the comparator tree.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ne_q <= '0;
    end else if (ne_clr_all) begin
      ne_q <= '0;
    end else if (ne_set) begin
      ne_q[list_q] <= 1'b1;
    end else if (ne_clr) begin
      ne_q[list_q] <= 1'b0;
    end
  end

  // Output register: valid bit with reset, payload without.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (act) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (act) begin
      status_q <= res_status;
      taken_q  <= (res_status == StatTaken) ? ValueW'(val_q) : '0;
      src_q    <= (res_status == StatTaken) ? SrcW'(list_q) : '0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign taken_value_o = taken_q;
  assign source_list_o = src_q;

  // A refill read only follows the lookup of a take.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFetch) |-> ($past(state_q) == StLookup) && (kind_q == KindTake))
    else $error("element refill outside a take");

  // A take only advances a list that holds an element.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (act && (kind_q == KindTake) && found_q) |-> ne_q[list_q])
    else $error("take from an empty list");

  // A load never writes beyond the last slot of its list.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    elem_we |-> in_range_q && (tbl_fill < PW'(LIST_DEPTH)))
    else $error("element write past the end of a list");

  // An accepted item always reaches the lookup cycle next.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == StLookup))
    else $error("accepted item not looked up");

endmodule

// ===== dv/k_way_sorted_merge_unit_tb.sv =====
// Self-checking testbench for the k-way sorted merge unit.
// Depends on kwm_pkg and k_way_sorted_merge_unit; an internal list predictor checks every result.
// Directed table first, then a full-list phase, then random merge batches with random idling.
`timescale 1ns / 1ps

module k_way_sorted_merge_unit_tb;
  import kwm_pkg::*;

  localparam int unsigned Lists     = 16;
  localparam int unsigned ListDepth = 512;
  localparam int unsigned ValueBits = 16;
  localparam int          RandItems = 200;

  // One result item as the unit returns it.
  typedef struct packed {
    status_e                   st;
    logic signed [ValueW-1:0]  val;
    logic [SrcW-1:0]           src;
  } merge_res_t;

  // One row of the directed table; want is used only where typed is set.
  typedef struct packed {
    kind_e                     op;
    logic [ListIdxW-1:0]       lst;
    logic signed [ValueW-1:0]  val;
    logic                      typed;
    merge_res_t                want;
  } dir_row_t;

  localparam merge_res_t Untyped = '0;

  localparam dir_row_t DirPlan [24] = '{
    // Nothing to take right after reset.
    '{KindTake,  4'd0,  16'h0000, 1'b1, '{StatEmpty,   16'h0000, 4'd0}},
    // The unused kind returns all fields zero.
    '{KindNone,  4'd0,  16'h0000, 1'b1, '{StatLoaded,  16'h0000, 4'd0}},
    '{KindClear, 4'd0,  16'h0000, 1'b1, '{StatCleared, 16'h0000, 4'd0}},
    '{KindLoad,  4'd0,  16'h8000, 1'b1, '{StatLoaded,  16'h0000, 4'd0}},
    '{KindLoad,  4'd15, 16'h7FFF, 1'b1, '{StatLoaded,  16'h0000, 4'd0}},
    '{KindLoad,  4'd3,  16'd100,  1'b0, Untyped},
    '{KindLoad,  4'd3,  16'd200,  1'b0, Untyped},
    // Equal heads on lists 3 and 7 must go to list 3 first.
    '{KindLoad,  4'd7,  16'd100,  1'b0, Untyped},
    '{KindLoad,  4'd0,  16'h8000, 1'b0, Untyped},
    '{KindTake,  4'd9,  16'h1234, 1'b0, Untyped},
    '{KindTake,  4'd6,  16'hABCD, 1'b0, Untyped},
    '{KindTake,  4'd0,  16'h0000, 1'b0, Untyped},
    '{KindTake,  4'd15, 16'hFFFF, 1'b0, Untyped},
    '{KindTake,  4'd0,  16'h0000, 1'b0, Untyped},
    // A descending pair: order inside a list is not checked by the unit.
    '{KindLoad,  4'd5,  16'h0000, 1'b0, Untyped},
    '{KindLoad,  4'd5,  16'hFFFF, 1'b0, Untyped},
    '{KindTake,  4'd0,  16'h0000, 1'b0, Untyped},
    '{KindTake,  4'd0,  16'h0000, 1'b0, Untyped},
    '{KindTake,  4'd0,  16'h0000, 1'b1, '{StatTaken,   16'h7FFF, 4'd15}},
    '{KindTake,  4'd0,  16'h0000, 1'b1, '{StatEmpty,   16'h0000, 4'd0}},
    '{KindLoad,  4'd9,  16'h7FFF, 1'b0, Untyped},
    '{KindClear, 4'd0,  16'h0000, 1'b1, '{StatCleared, 16'h0000, 4'd0}},
    '{KindTake,  4'd0,  16'h0000, 1'b1, '{StatEmpty,   16'h0000, 4'd0}},
    '{KindNone,  4'd15, 16'hFFFF, 1'b1, '{StatLoaded,  16'h0000, 4'd0}}
  };

  logic                      clk_i      = 1'b0;
  logic                      rst_ni     = 1'b0;
  logic                      in_valid   = 1'b0;
  logic                      in_stall;
  logic [KindW-1:0]          in_kind    = '0;
  logic [ListIdxW-1:0]       in_list    = '0;
  logic signed [ValueW-1:0]  in_value   = '0;
  logic                      out_valid;
  logic                      out_stall  = 1'b0;
  logic [StatusW-1:0]        out_status;
  logic signed [ValueW-1:0]  out_taken;
  logic [SrcW-1:0]           out_src;

  // Predicted list contents.
  logic signed [ValueW-1:0]  list_mem  [Lists][ListDepth];
  logic signed [ValueW-1:0]  list_head [Lists];
  int                        list_rd   [Lists];
  int                        list_fill [Lists];

  // Stimulus side: last value appended per list, to keep lists ascending.
  int                        list_tail [Lists];
  bit                        tail_set  [Lists];

  merge_res_t                awaited_results [$];
  int                        items_sent   = 0;
  int                        results_seen = 0;
  int                        mismatch_cnt = 0;
  int                        burst_left   = 0;

  k_way_sorted_merge_unit #(
    .LISTS      (Lists),
    .LIST_DEPTH (ListDepth),
    .VALUE_WIDTH(ValueBits)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .kind_i       (in_kind),
    .list_index_i (in_list),
    .value_i      (in_value),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .status_o     (out_status),
    .taken_value_o(out_taken),
    .source_list_o(out_src)
  );

  always #1 clk_i = ~clk_i;

  // Applies one item to the predicted lists and returns the result it causes.
  function automatic merge_res_t merge_outcome(input kind_e op,
                                               input logic [ListIdxW-1:0] lst,
                                               input logic signed [ValueW-1:0] val);
    merge_res_t r;
    int best;
    r = '0;
    case (op)
      KindLoad: begin
        if (int'(lst) >= Lists || list_fill[lst] >= ListDepth) begin
          r.st = StatDropped;
        end else begin
          list_mem[lst][list_fill[lst]] = val;
          if (list_rd[lst] >= list_fill[lst]) list_head[lst] = val;
          list_fill[lst]++;
          r.st = StatLoaded;
        end
      end
      KindTake: begin
        best = -1;
        for (int i = 0; i < Lists; i++) begin
          if (list_rd[i] < list_fill[i] && (best < 0 || list_head[i] < list_head[best])) begin
            best = i;
          end
        end
        if (best < 0) begin
          r.st = StatEmpty;
        end else begin
          r.st  = StatTaken;
          r.val = list_head[best];
          r.src = SrcW'(best);
          list_rd[best]++;
          if (list_rd[best] < list_fill[best]) list_head[best] = list_mem[best][list_rd[best]];
        end
      end
      KindClear: begin
        for (int i = 0; i < Lists; i++) begin
          list_rd[i]   = 0;
          list_fill[i] = 0;
        end
        r.st = StatCleared;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Number of elements still waiting in all lists.
  function automatic int lists_held();
    int n;
    n = 0;
    for (int i = 0; i < Lists; i++) n += list_fill[i] - list_rd[i];
    return n;
  endfunction

  // Offers one item, inserting a random gap between bursts, and records its result
  // once the input transfer has happened.
  task automatic offer_item(input kind_e op, input logic [ListIdxW-1:0] lst,
                            input logic signed [ValueW-1:0] val,
                            input logic typed = 1'b0, input merge_res_t want = '0);
    merge_res_t got;
    bit taken_in;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 8));
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_kind  <= op;
    in_list  <= lst;
    in_value <= val;
    // Inputs only move at rising edges, so the stall seen at the falling edge
    // decides the transfer at the next rising edge.
    do begin
      @(negedge clk_i);
      taken_in = !in_stall;
      @(posedge clk_i);
    end while (!taken_in);
    got = merge_outcome(op, lst, val);
    awaited_results.push_back(typed ? want : got);
    items_sent++;
    // Once every list is empty, any new content may start from any value.
    if (lists_held() == 0) begin
      for (int i = 0; i < Lists; i++) tail_set[i] = 1'b0;
    end
  endtask

  // Appends a value no smaller than the list's last one.
  task automatic offer_ascending(input logic [ListIdxW-1:0] lst, input int max_step);
    int nv;
    if (!tail_set[lst]) begin
      case ($urandom_range(0, 5))
        0:       nv = -32768;
        1:       nv = 32767 - int'($urandom_range(0, 50));
        default: nv = int'($urandom_range(0, 65535)) - 32768;
      endcase
    end else begin
      nv = list_tail[lst] + (($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, max_step)));
      if (nv > 32767) nv = 32767;
    end
    list_tail[lst] = nv;
    tail_set[lst]  = 1'b1;
    offer_item(KindLoad, lst, 16'(nv));
  endtask

  // Stops offering until every awaited result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (awaited_results.size() != 0);
  endtask

  // A merge batch: ascending loads into a few lists with some takes mixed in,
  // then either a full drain (sometimes one take past empty) or a clear.
  task automatic run_merge_batch();
    logic [ListIdxW-1:0] used [4];
    int n_lists;
    n_lists = $urandom_range(1, 4);
    for (int j = 0; j < 4; j++) used[j] = ListIdxW'($urandom);
    repeat ($urandom_range(2, 20)) begin
      if ($urandom_range(0, 3) == 0 && lists_held() > 0) begin
        offer_item(KindTake, ListIdxW'($urandom), ValueW'($urandom));
      end
      offer_ascending(used[$urandom_range(0, n_lists - 1)], 2000);
    end
    if ($urandom_range(0, 4) == 0) begin
      offer_item(KindClear, ListIdxW'($urandom), ValueW'($urandom));
    end else begin
      repeat (lists_held() + (($urandom_range(0, 2) == 0) ? 1 : 0)) begin
        offer_item(KindTake, ListIdxW'($urandom), ValueW'($urandom));
      end
    end
  endtask

  // Stimulus: reset, directed table, full-list phase, random batches, drain.
  initial begin : stimulus
    int rand_start;
    logic [ListIdxW-1:0] full_list;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < 24; r++) begin
      offer_item(DirPlan[r].op, DirPlan[r].lst, DirPlan[r].val, DirPlan[r].typed,
                 DirPlan[r].want);
    end
    wait_drained();

    // Fill one list to its depth; further loads are dropped, and slots freed by
    // takes stay unused until the next clear.
    full_list = ListIdxW'($urandom);
    offer_item(KindClear, 4'd0, 16'h0000);
    repeat (ListDepth) offer_ascending(full_list, 100);
    repeat (3) offer_ascending(full_list, 100);
    repeat (5) offer_item(KindTake, ListIdxW'($urandom), ValueW'($urandom));
    offer_ascending(full_list, 100);
    offer_ascending(full_list + 4'd1, 100);
    repeat (3) offer_item(KindTake, ListIdxW'($urandom), ValueW'($urandom));
    offer_item(KindClear, ListIdxW'($urandom), ValueW'($urandom));

    // Random part: mostly well-formed merge batches, some noise.
    rand_start = items_sent;
    while (items_sent - rand_start < RandItems) begin
      if ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(3, 10)) begin
          offer_item(kind_e'(2'($urandom)), ListIdxW'($urandom), ValueW'($urandom));
        end
      end else begin
        run_merge_batch();
      end
      if ($urandom_range(0, 19) == 0) wait_drained();
    end

    wait_drained();
    repeat (16) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Receiver: a series of random stall patterns, plus one long hold-off that makes
  // the unit back up and stall its input.
  initial begin : receiver
    int mode;
    int span;
    bit held_once;
    held_once = 1'b0;
    @(posedge rst_ni);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(8, 80);
      repeat (span) begin
        @(posedge clk_i);
        if (!held_once && results_seen >= 100) begin
          held_once = 1'b1;
          out_stall <= 1'b1;
          repeat (300) @(posedge clk_i);
        end else begin
          case (mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            2:       out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= ~out_stall;
          endcase
        end
      end
    end
  end

  // Result check: an output transfer is decided by the values at the falling edge.
  always @(negedge clk_i) begin : result_check
    merge_res_t want;
    if (rst_ni && out_valid && !out_stall) begin
      results_seen++;
      if (awaited_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
          $display("%0t: result with nothing awaited: status %0d value %0d list %0d",
                   $time, out_status, out_taken, out_src);
        end
      end else begin
        want = awaited_results.pop_front();
        if (out_status !== want.st || out_taken !== want.val || out_src !== want.src) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("%0t: result %0d: status exp %0d got %0d, value exp %0d got %0d, %s",
                     $time, results_seen, want.st, out_status, want.val, out_taken,
                     $sformatf("list exp %0d got %0d", want.src, out_src));
          end
        end
      end
    end
  end

  // Run limit, far beyond the slowest correct run.
  initial begin : run_limit
    #800_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/kwm_pkg.sv
hw/rtl/kwm_elem_ram.sv
hw/rtl/kwm_list_table.sv
hw/rtl/kwm_min_tree.sv
hw/rtl/k_way_sorted_merge_unit.sv
dv/k_way_sorted_merge_unit_tb.sv
